>>> sv/d2d_pkg.sv
// Shared types, constants and helper functions for the day count to date converter.
`timescale 1ns / 1ps

package d2d_pkg;

    // Last supported year index; later day counts saturate to its last day
    localparam int unsigned LAST_YEAR_INDEX = 9998;

    // Field widths
    localparam int unsigned DAY_W   = 22;
    localparam int unsigned ACC_W   = DAY_W + 1;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned STEP_W  = 5;

    // Days before the first day after the last supported year
    localparam longint unsigned YEAR_SPAN = longint'(LAST_YEAR_INDEX) + 1;
    localparam longint unsigned DAY_LIMIT =
        YEAR_SPAN * 365 + YEAR_SPAN / 4 - YEAR_SPAN / 100 + YEAR_SPAN / 400;
    localparam longint unsigned DAY_SPACE = longint'(1) << DAY_W;

    // Limit as seen by the datapath: a limit beyond the input range never triggers
    localparam logic [ACC_W-1:0] SAT_LIMIT =
        (DAY_LIMIT > DAY_SPACE) ? ACC_W'(DAY_SPACE) : ACC_W'(DAY_LIMIT);
    localparam logic [DAY_W-1:0] SAT_DAY = DAY_W'(SAT_LIMIT - ACC_W'(1));

    // Cycle lengths in days, as datapath operands
    localparam logic [ACC_W-1:0] DAYS_400 = ACC_W'(146097);
    localparam logic [ACC_W-1:0] DAYS_100 = ACC_W'(36524);
    localparam logic [ACC_W-1:0] DAYS_4   = ACC_W'(1461);
    localparam logic [ACC_W-1:0] DAYS_1   = ACC_W'(365);
    localparam logic [ACC_W-1:0] WEEK     = ACC_W'(7);

    // Year increments matching each cycle length
    localparam logic [YEAR_W-1:0] YEARS_400 = YEAR_W'(400);
    localparam logic [YEAR_W-1:0] YEARS_100 = YEAR_W'(100);
    localparam logic [YEAR_W-1:0] YEARS_4   = YEAR_W'(4);
    localparam logic [YEAR_W-1:0] YEARS_1   = YEAR_W'(1);

    // Highest shift of each long division pass (counted down to zero)
    localparam logic [STEP_W-1:0] WDAY_TOP   = STEP_W'(19);
    localparam logic [STEP_W-1:0] Q400_TOP   = STEP_W'(4);
    localparam logic [STEP_W-1:0] Q4_TOP     = STEP_W'(4);
    localparam logic [STEP_W-1:0] CAP_TOP    = STEP_W'(2);
    localparam logic [4:0]        N4_CENTURY = 5'd24;

    // Month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

    // One finished date
    typedef struct packed {
        logic [YEAR_W-1:0]  year_index;
        logic [MONTH_W-1:0] month_index;
        logic [DOM_W-1:0]   day_in_month;
        logic [DOY_W-1:0]   day_in_year;
        logic [WDAY_W-1:0]  weekday;
        logic               leap_year;
        logic               out_of_range;
    } t_result;

    // Control from the top level into the sequencer
    typedef struct packed {
        logic start;
        logic take;
    } t_seq_ctl;

    // Status from the sequencer to the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    // Length of a month in days
    function automatic logic [DOM_W:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DOM_W:0] len;
        case (m) inside
            MON_FEB:                          len = leap ? 6'd29 : 6'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 6'd30;
            default:                          len = 6'd31;
        endcase
        return len;
    endfunction

endpackage

>>> sv/d2d_alu.sv
// Shared subtract-and-compare unit of the day count converter.
`timescale 1ns / 1ps

module d2d_alu (
    input  logic [d2d_pkg::ACC_W-1:0] i_a,
    input  logic [d2d_pkg::ACC_W-1:0] i_b,
    output logic [d2d_pkg::ACC_W-1:0] o_diff,
    output logic                      o_ge
);

    logic [d2d_pkg::ACC_W:0] w_full;

    // Subtract with one extra bit for the borrow
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[d2d_pkg::ACC_W-1:0];
    assign o_ge   = ~w_full[d2d_pkg::ACC_W];

endmodule

>>> sv/d2d_seq.sv
// Sequencer and working registers that drive the shared subtract unit.
`timescale 1ns / 1ps

module d2d_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  d2d_pkg::t_seq_ctl         i_ctl,
    input  logic [d2d_pkg::DAY_W-1:0] i_day_count,
    input  logic [2:0]                i_first_day_of_week,
    output d2d_pkg::t_seq_stat        o_stat,
    output d2d_pkg::t_result          o_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAT,
        S_WDAY,
        S_Y400,
        S_Y100,
        S_Y4,
        S_Y1,
        S_MON,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic [d2d_pkg::STEP_W-1:0]        r_k;
    logic [d2d_pkg::DAY_W-1:0]         r_day;
    logic [d2d_pkg::ACC_W-1:0]         r_rem;
    logic                              r_flag;
    logic [d2d_pkg::YEAR_W-1:0]        r_year;
    logic [1:0]                        r_n100;
    logic [4:0]                        r_n4;
    logic [1:0]                        r_n1;
    logic [d2d_pkg::MONTH_W-1:0]       r_month;
    logic [d2d_pkg::DOY_W-1:0]         r_doy;
    logic [d2d_pkg::WDAY_W-1:0]        r_wrem;

    logic [d2d_pkg::ACC_W-1:0]         w_b;
    logic [d2d_pkg::ACC_W-1:0]         w_diff;
    logic                              w_ge;
    logic [d2d_pkg::YEAR_W-1:0]        w_year_inc;
    logic                              w_leap;
    logic [d2d_pkg::WDAY_W:0]          w_wsum;
    logic [d2d_pkg::WDAY_W-1:0]        w_weekday;
    logic [d2d_pkg::ACC_W-1:0]         w_rem_next;
    logic                              w_last;

    // Leap when the year closes a 4-year cycle, unless it is a plain century year
    assign w_leap = (r_n1 == 2'd3) && ((r_n4 != d2d_pkg::N4_CENTURY) || (r_n100 == 2'd3));

    // Select the subtrahend and the year increment for the current step
    always_comb begin
        w_b        = '0;
        w_year_inc = '0;
        unique case (r_state)
            S_SAT: begin
                w_b = d2d_pkg::SAT_LIMIT;
            end
            S_WDAY: begin
                w_b = d2d_pkg::WEEK << r_k;
            end
            S_Y400: begin
                w_b        = d2d_pkg::DAYS_400 << r_k[2:0];
                w_year_inc = d2d_pkg::YEARS_400 << r_k[2:0];
            end
            S_Y100: begin
                w_b        = d2d_pkg::DAYS_100;
                w_year_inc = d2d_pkg::YEARS_100;
            end
            S_Y4: begin
                w_b        = d2d_pkg::DAYS_4 << r_k[2:0];
                w_year_inc = d2d_pkg::YEARS_4 << r_k[2:0];
            end
            S_Y1: begin
                w_b        = d2d_pkg::DAYS_1;
                w_year_inc = d2d_pkg::YEARS_1;
            end
            S_MON: begin
                w_b = d2d_pkg::ACC_W'(d2d_pkg::month_len(r_month, w_leap));
            end
            default: begin
                w_b        = '0;
                w_year_inc = '0;
            end
        endcase
    end

    d2d_alu u_alu (
        .i_a    (r_rem),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // Keep the difference only when it did not borrow
    assign w_rem_next = w_ge ? w_diff : r_rem;
    assign w_last     = (r_k == '0);

    // Sequence the division passes and the month walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_day   <= i_day_count;
                        r_rem   <= {1'b0, i_day_count};
                        r_flag  <= 1'b0;
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (w_ge) begin
                        r_day  <= d2d_pkg::SAT_DAY;
                        r_rem  <= {1'b0, d2d_pkg::SAT_DAY};
                        r_flag <= 1'b1;
                    end
                    r_k     <= d2d_pkg::WDAY_TOP;
                    r_state <= S_WDAY;
                end
                S_WDAY: begin
                    if (w_last) begin
                        r_wrem  <= w_rem_next[d2d_pkg::WDAY_W-1:0];
                        r_rem   <= {1'b0, r_day};
                        r_year  <= '0;
                        r_k     <= d2d_pkg::Q400_TOP;
                        r_state <= S_Y400;
                    end else begin
                        r_rem <= w_rem_next;
                        r_k   <= r_k - d2d_pkg::STEP_W'(1);
                    end
                end
                S_Y400: begin
                    r_rem <= w_rem_next;
                    if (w_ge) begin
                        r_year <= r_year + w_year_inc;
                    end
                    if (w_last) begin
                        r_n100  <= '0;
                        r_k     <= d2d_pkg::CAP_TOP;
                        r_state <= S_Y100;
                    end else begin
                        r_k <= r_k - d2d_pkg::STEP_W'(1);
                    end
                end
                S_Y100: begin
                    r_rem <= w_rem_next;
                    if (w_ge) begin
                        r_year <= r_year + w_year_inc;
                        r_n100 <= r_n100 + 2'd1;
                    end
                    if (w_last) begin
                        r_n4    <= '0;
                        r_k     <= d2d_pkg::Q4_TOP;
                        r_state <= S_Y4;
                    end else begin
                        r_k <= r_k - d2d_pkg::STEP_W'(1);
                    end
                end
                S_Y4: begin
                    r_rem <= w_rem_next;
                    if (w_ge) begin
                        r_year            <= r_year + w_year_inc;
                        r_n4[r_k[2:0]]    <= 1'b1;
                    end
                    if (w_last) begin
                        r_n1    <= '0;
                        r_k     <= d2d_pkg::CAP_TOP;
                        r_state <= S_Y1;
                    end else begin
                        r_k <= r_k - d2d_pkg::STEP_W'(1);
                    end
                end
                S_Y1: begin
                    r_rem <= w_rem_next;
                    if (w_ge) begin
                        r_year <= r_year + w_year_inc;
                        r_n1   <= r_n1 + 2'd1;
                    end
                    if (w_last) begin
                        r_doy   <= w_rem_next[d2d_pkg::DOY_W-1:0];
                        r_month <= d2d_pkg::MON_JAN;
                        r_state <= S_MON;
                    end else begin
                        r_k <= r_k - d2d_pkg::STEP_W'(1);
                    end
                end
                S_MON: begin
                    if (w_ge && (r_month != d2d_pkg::MON_DEC)) begin
                        r_rem   <= w_diff;
                        r_month <= r_month + 4'd1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ctl.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Fold in the weekday of day zero; the sum stays below twice a week
    assign w_wsum    = {1'b0, r_wrem} + {1'b0, i_first_day_of_week};
    assign w_weekday = (w_wsum >= 4'd7) ? d2d_pkg::WDAY_W'(w_wsum - 4'd7)
                                        : w_wsum[d2d_pkg::WDAY_W-1:0];

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    assign o_result.year_index   = r_year;
    assign o_result.month_index  = r_month;
    assign o_result.day_in_month = r_rem[d2d_pkg::DOM_W-1:0];
    assign o_result.day_in_year  = r_doy;
    assign o_result.weekday      = w_weekday;
    assign o_result.leap_year    = w_leap;
    assign o_result.out_of_range = r_flag;

endmodule

>>> sv/day_count_to_date_core.sv
// Top level of the day count to Gregorian date converter.
`timescale 1ns / 1ps

// Converts a 22-bit count of days since the first day of year index 0 into
// year index, month, day of month, day of year, weekday and leap flag. Each
// transaction is worked by one 23-bit subtract-and-compare unit stepped by a
// sequencer: one saturation check, 20 long-division steps for the weekday,
// 5 + 3 + 5 + 3 steps for the 400/100/4/1-year cycles and 1 to 12 steps of
// the month walk. The finished date moves into the output register once it is
// empty or not stalled. The input stall stays high while a transaction is
// being worked; the next transaction is taken as soon as the previous result
// has moved to the output register. Counts past the last supported year give
// that year's last day with o_out_of_range set.
// The first day of week register resets to 1 (Monday); write it only while
// the block is idle.

module day_count_to_date_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [21:0] i_day_count,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_year_index,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_in_month,
    output logic [8:0]  o_day_in_year,
    output logic [2:0]  o_weekday,
    output logic        o_leap_year,
    output logic        o_out_of_range
);

    logic [2:0]          r_first_day_of_week;
    logic                r_out_valid;
    d2d_pkg::t_result    r_out;

    d2d_pkg::t_seq_ctl   w_ctl;
    d2d_pkg::t_seq_stat  w_stat;
    d2d_pkg::t_result    w_result;

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_day_of_week <= 3'd1;
        end else if (i_cfg_wen) begin
            r_first_day_of_week <= i_cfg_wdata;
        end
    end

    // Start on an accepted transaction; drain into a free output register
    assign w_ctl.start = i_valid && w_stat.idle;
    assign w_ctl.take  = w_stat.done && (!r_out_valid || !i_stall);
    assign o_stall     = !w_stat.idle;

    d2d_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_ctl),
        .i_day_count         (i_day_count),
        .i_first_day_of_week (r_first_day_of_week),
        .o_stat              (w_stat),
        .o_result            (w_result)
    );

    // Output register: load a finished date, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.take) begin
            r_out_valid <= 1'b1;
            r_out       <= w_result;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_year_index   = r_out.year_index;
    assign o_month_index  = r_out.month_index;
    assign o_day_in_month = r_out.day_in_month;
    assign o_day_in_year  = r_out.day_in_year;
    assign o_weekday      = r_out.weekday;
    assign o_leap_year    = r_out.leap_year;
    assign o_out_of_range = r_out.out_of_range;

`ifndef NO_ASSERTIONS
    // An accepted transaction keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took a transaction but was not busy afterwards");

    // A delivered weekday and month stay inside their ranges
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday != 3'd7) && (o_month_index <= 4'd11))
        else $error("weekday or month out of range");

    // A saturated result lands on the last supported year
    a_saturated_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |->
            (o_year_index == 14'(d2d_pkg::LAST_YEAR_INDEX)))
        else $error("saturated result is not in the last supported year");

    // Day of month never runs ahead of day of year
    a_day_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({4'd0, o_day_in_month} <= o_day_in_year))
        else $error("day of month exceeds day of year");
`endif

endmodule
